/* src/fbd_pkg.sv */
// Shared types and constants of the flat block detector.
package fbd_pkg;

  localparam int BLOCK_SIZE     = 64;
  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int BLK_BITS       = $clog2(BLOCK_SIZE);
  localparam int NUM_BLOCK_COLS = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BC_BITS        = $clog2(NUM_BLOCK_COLS);
  localparam int SEG_W          = $clog2(BLOCK_SIZE + 1);
  localparam int CFG_W          = 13;
  localparam int CNT_W          = 13;
  localparam int POS_W          = 12;
  localparam int PIX_W          = 8;
  localparam int IDX_W          = 2;
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FLAT_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 13'd64;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 13'd64;
  localparam logic [CFG_W-1:0] RST_FLAT_THRESHOLD = 13'd3891;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [CFG_W-1:0] flat_threshold;
  } cfg_t;

  // One classified pixel as it travels from the front to the back
  typedef struct packed {
    logic               is_zero;
    logic [BC_BITS-1:0] bc;
    logic [POS_W-1:0]   blk_index;
    logic               seg_end;    // last pixel of this block column in the row
    logic               close;      // block closes here
    logic               frame_end;
    logic               band_clr;   // all column counts clear after this pixel
  } pix_t;

  typedef struct packed {
    logic             block_valid;
    logic [POS_W-1:0] block_index;
    logic             frame_end;
    logic [CNT_W-1:0] flat_total;
  } res_t;

endpackage

/* src/fbd_front.sv */
// Front part: tracks raster position and classifies each accepted pixel.
module fbd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  fbd_pkg::cfg_t             cfg,
  input  logic                      push,
  input  logic [fbd_pkg::PIX_W-1:0] edge_value,
  input  logic                      q_full,
  output logic                      q_wr,
  output fbd_pkg::pix_t             q_data
);

  logic [fbd_pkg::POS_W-1:0]   pixel_column;
  logic [fbd_pkg::POS_W-1:0]   pixel_row;
  logic [fbd_pkg::POS_W-1:0]   band_start_index;
  logic [fbd_pkg::CFG_W-1:0]   w_c;
  logic [fbd_pkg::CFG_W-1:0]   h_c;
  logic [fbd_pkg::CFG_W:0]     nbc_sum;
  logic [fbd_pkg::BC_BITS-1:0] bc;
  logic                        row_end;
  logic                        frame_end;
  logic                        band_end;
  logic                        block_end;

  always_comb begin
    priority if (cfg.image_width == '0) begin
      w_c = fbd_pkg::CFG_W'(1);
    end else if (cfg.image_width > fbd_pkg::CFG_W'(fbd_pkg::MAX_WIDTH)) begin
      w_c = fbd_pkg::CFG_W'(fbd_pkg::MAX_WIDTH);
    end else begin
      w_c = cfg.image_width;
    end
    priority if (cfg.image_height == '0) begin
      h_c = fbd_pkg::CFG_W'(1);
    end else if (cfg.image_height > fbd_pkg::CFG_W'(fbd_pkg::MAX_HEIGHT)) begin
      h_c = fbd_pkg::CFG_W'(fbd_pkg::MAX_HEIGHT);
    end else begin
      h_c = cfg.image_height;
    end
  end

  assign nbc_sum   = {1'b0, w_c} + (fbd_pkg::CFG_W + 1)'(fbd_pkg::BLOCK_SIZE - 1);
  assign bc        = fbd_pkg::BC_BITS'(pixel_column >> fbd_pkg::BLK_BITS);
  assign row_end   = ({1'b0, pixel_column} + fbd_pkg::CFG_W'(1)) >= w_c;
  assign frame_end = row_end && (({1'b0, pixel_row} + fbd_pkg::CFG_W'(1)) >= h_c);
  assign band_end  = (pixel_row[fbd_pkg::BLK_BITS-1:0] ==
                      fbd_pkg::BLK_BITS'(fbd_pkg::BLOCK_SIZE - 1)) ||
                     (({1'b0, pixel_row} + fbd_pkg::CFG_W'(1)) >= h_c);
  assign block_end = (pixel_column[fbd_pkg::BLK_BITS-1:0] ==
                      fbd_pkg::BLK_BITS'(fbd_pkg::BLOCK_SIZE - 1)) || row_end;

  assign q_wr = push && !q_full;

  always_comb begin
    q_data.is_zero   = (edge_value == '0);
    q_data.bc        = bc;
    q_data.blk_index = band_start_index + fbd_pkg::POS_W'(bc);
    q_data.seg_end   = block_end;
    q_data.close     = band_end && block_end;
    q_data.frame_end = frame_end;
    q_data.band_clr  = row_end && band_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column     <= '0;
      pixel_row        <= '0;
      band_start_index <= '0;
    end else if (q_wr) begin
      priority if (frame_end) begin
        pixel_column     <= '0;
        pixel_row        <= '0;
        band_start_index <= '0;
      end else if (row_end) begin
        pixel_column <= '0;
        pixel_row    <= pixel_row + fbd_pkg::POS_W'(1);
        if (band_end) begin
          band_start_index <= band_start_index +
                              fbd_pkg::POS_W'(nbc_sum >> fbd_pkg::BLK_BITS);
        end
      end else begin
        pixel_column <= pixel_column + fbd_pkg::POS_W'(1);
      end
    end
  end

endmodule

/* src/fbd_queue.sv */
// Short queue of classified pixels between the front and the back.
module fbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  fbd_pkg::pix_t wr_data,
  output logic          full,
  input  logic          rd,
  output fbd_pkg::pix_t rd_data,
  output logic          empty
);

  fbd_pkg::pix_t                 slots [fbd_pkg::Q_DEPTH];
  logic [fbd_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [fbd_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [fbd_pkg::Q_CNT_W-1:0]   count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == fbd_pkg::Q_CNT_W'(fbd_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + fbd_pkg::Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + fbd_pkg::Q_PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + fbd_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - fbd_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/fbd_back.sv */
// Back part: column zero counts, block close decision and the result queue.
module fbd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fbd_pkg::CFG_W-1:0] flat_threshold,
  input  fbd_pkg::pix_t             q_head,
  input  logic                      q_empty,
  output logic                      q_rd,
  input  logic                      pop,
  output logic                      empty,
  output fbd_pkg::res_t             res
);

  // Column count store with one valid bit per entry
  logic [fbd_pkg::CNT_W-1:0]          mem [fbd_pkg::NUM_BLOCK_COLS];
  logic [fbd_pkg::NUM_BLOCK_COLS-1:0] col_valid;

  logic [fbd_pkg::SEG_W-1:0] seg_acc;
  logic [fbd_pkg::SEG_W-1:0] seg_sum;

  // Stage 2: one segment end per entry
  logic                      s2_full;
  fbd_pkg::pix_t             s2;
  logic [fbd_pkg::SEG_W-1:0] s2_seg;
  logic                      s2_byp;
  logic [fbd_pkg::CNT_W-1:0] s2_byp_val;
  logic [fbd_pkg::CNT_W-1:0] rdata;
  logic                      rvalid;

  logic [fbd_pkg::CNT_W-1:0] base;
  logic [fbd_pkg::CNT_W-1:0] total;
  logic                      flat;
  logic                      s2_has_res;
  logic                      s2_fire;
  logic                      s2_ready;
  logic                      s2_load;
  logic [fbd_pkg::CNT_W-1:0] flat_count;
  logic [fbd_pkg::CNT_W-1:0] flat_inc;

  // Result queue
  fbd_pkg::res_t               out_q [fbd_pkg::Q_DEPTH];
  logic [fbd_pkg::Q_PTR_W-1:0] out_wr_ptr;
  logic [fbd_pkg::Q_PTR_W-1:0] out_rd_ptr;
  logic [fbd_pkg::Q_CNT_W-1:0] out_count;
  logic                        out_full;
  logic                        out_push;
  logic                        out_pop;
  fbd_pkg::res_t               out_res;

  assign out_full = (out_count == fbd_pkg::Q_CNT_W'(fbd_pkg::Q_DEPTH));
  assign empty    = (out_count == '0);
  assign out_pop  = pop && !empty;
  assign res      = out_q[out_rd_ptr];

  assign base       = s2_byp ? s2_byp_val : (rvalid ? rdata : '0);
  assign total      = base + fbd_pkg::CNT_W'(s2_seg);
  assign flat       = s2.close && (total >= flat_threshold);
  assign s2_has_res = flat || s2.frame_end;
  assign s2_fire    = s2_full && (!s2_has_res || !out_full);
  assign s2_ready   = !s2_full || s2_fire;
  assign q_rd       = !q_empty && (!q_head.seg_end || s2_ready);
  assign s2_load    = q_rd && q_head.seg_end;
  assign seg_sum    = seg_acc + fbd_pkg::SEG_W'(q_head.is_zero);
  assign out_push   = s2_fire && s2_has_res;
  assign flat_inc   = (flat_count == fbd_pkg::CNT_MAX) ? flat_count :
                      flat_count + fbd_pkg::CNT_W'(1);

  always_comb begin
    out_res.block_valid = flat;
    out_res.block_index = flat ? s2.blk_index : '0;
    out_res.frame_end   = s2.frame_end;
    out_res.flat_total  = flat ? flat_inc : flat_count;
  end

  // Segment accumulator: zero pixels of the current run within one block column
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_acc <= '0;
    end else if (q_rd) begin
      seg_acc <= q_head.seg_end ? '0 : seg_sum;
    end
  end

  // Stage 2 load; forward the value written by stage 2 on the same edge
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2     <= q_head;
      s2_seg <= seg_sum;
      rdata  <= mem[q_head.bc];
      rvalid <= col_valid[q_head.bc];
      s2_byp <= s2_fire && (s2.band_clr || (s2.bc == q_head.bc));
      s2_byp_val <= (s2.band_clr || s2.close) ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_full <= 1'b0;
    end else if (s2_load) begin
      s2_full <= 1'b1;
    end else if (s2_fire) begin
      s2_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && !s2.close) begin
      mem[s2.bc] <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (s2_fire) begin
      priority if (s2.band_clr) begin
        col_valid <= '0;
      end else if (s2.close) begin
        col_valid[s2.bc] <= 1'b0;
      end else begin
        col_valid[s2.bc] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_count <= '0;
    end else if (s2_fire) begin
      priority if (s2.frame_end) begin
        flat_count <= '0;
      end else if (flat) begin
        flat_count <= flat_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_q[out_wr_ptr] <= out_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (out_push) begin
        out_wr_ptr <= out_wr_ptr + fbd_pkg::Q_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + fbd_pkg::Q_PTR_W'(1);
      end
      unique case ({out_push, out_pop})
        2'b10:   out_count <= out_count + fbd_pkg::Q_CNT_W'(1);
        2'b01:   out_count <= out_count - fbd_pkg::Q_CNT_W'(1);
        default: out_count <= out_count;
      endcase
    end
  end

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_acc <= fbd_pkg::SEG_W'(fbd_pkg::BLOCK_SIZE))
    else $error("segment accumulator exceeds block width");

  a_frame_total_clear: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && s2.frame_end) |=> (flat_count == '0))
    else $error("flat total not cleared after frame end");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (!out_full || out_pop))
    else $error("result queue overflow");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s2_full && !s2_fire) |=> (s2_full && $stable(s2_seg) && $stable(s2.bc)))
    else $error("stalled stage 2 entry changed");

endmodule

/* src/flat_block_detector.sv */
// Top level of the flat block detector: configuration registers and part wiring.
// A pixel passes the pixel queue and stage 2; any result it causes waits in the result queue.
// Throughput: one pixel per cycle; the front takes a pixel whenever the 4-entry pixel
//   queue has room; the back drains one per cycle unless a full result queue stalls stage 2.
// Reset (synchronous, rst high): position, band start, flat total, column count valid
//   bits and both queues clear; registers return to 64, 64 and 3891.
module flat_block_detector (
  input  logic                      clk,
  input  logic                      rst,
  // pixel request side
  input  logic                      push,
  output logic                      full,
  input  logic [fbd_pkg::PIX_W-1:0] edge_value,
  // result request side
  output logic                      empty,
  input  logic                      pop,
  output logic                      block_valid,
  output logic [fbd_pkg::POS_W-1:0] block_index,
  output logic                      frame_end,
  output logic [fbd_pkg::CNT_W-1:0] flat_total,
  // configuration writes
  input  logic                      cfg_write,
  input  logic [fbd_pkg::IDX_W-1:0] cfg_index,
  input  logic [fbd_pkg::CFG_W-1:0] cfg_data
);

  fbd_pkg::cfg_t cfg;
  fbd_pkg::pix_t q_in;
  fbd_pkg::pix_t q_head;
  fbd_pkg::res_t res;
  logic          q_wr;
  logic          q_rd;
  logic          q_full;
  logic          q_empty;

  // Configuration registers; writes to an index past the list drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= fbd_pkg::RST_IMAGE_WIDTH;
      cfg.image_height   <= fbd_pkg::RST_IMAGE_HEIGHT;
      cfg.flat_threshold <= fbd_pkg::RST_FLAT_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fbd_pkg::REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data;
        fbd_pkg::REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        fbd_pkg::REG_FLAT_THRESHOLD: cfg.flat_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold pixels off while the pixel queue is full
  assign full = q_full;

  // Front: raster position and per-pixel classification
  fbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .edge_value (edge_value),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_data     (q_in)
  );

  // Decoupling queue between classification and counting
  fbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_in),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Back: column counts, flat decision, result queue
  fbd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .flat_threshold (cfg.flat_threshold),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .res            (res)
  );

  assign block_valid = res.block_valid;
  assign block_index = res.block_index;
  assign frame_end   = res.frame_end;
  assign flat_total  = res.flat_total;

endmodule

/* tb/tb_flat_block_detector.sv */
// Self-checking testbench for the flat block detector: directed geometries plus random frames.
`timescale 1ns / 100ps

module tb_flat_block_detector;

  // Cycles to wait after the last expected result before touching the registers
  // or ending the run.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with neither a pixel nor a result accepted before the run is abandoned.
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 220;
  localparam int RANDOM_RESULTS = 8;

  typedef enum int {IDLE_NONE, IDLE_ANY, IDLE_SPARSE} idle_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [fbd_pkg::PIX_W-1:0] edge_value = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic                      block_valid;
  logic [fbd_pkg::POS_W-1:0] block_index;
  logic                      frame_end;
  logic [fbd_pkg::CNT_W-1:0] flat_total;
  logic                      cfg_write = 1'b0;
  logic [fbd_pkg::IDX_W-1:0] cfg_index = fbd_pkg::REG_IMAGE_WIDTH;
  logic [fbd_pkg::CFG_W-1:0] cfg_data = '0;

  flat_block_detector dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .edge_value  (edge_value),
    .empty       (empty),
    .pop         (pop),
    .block_valid (block_valid),
    .block_index (block_index),
    .frame_end   (frame_end),
    .flat_total  (flat_total),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copies and the detector's own state, kept in step with
  // every accepted pixel.
  // ---------------------------------------------------------------------------
  logic [fbd_pkg::CFG_W-1:0] reg_width     = fbd_pkg::RST_IMAGE_WIDTH;
  logic [fbd_pkg::CFG_W-1:0] reg_height    = fbd_pkg::RST_IMAGE_HEIGHT;
  logic [fbd_pkg::CFG_W-1:0] reg_threshold = fbd_pkg::RST_FLAT_THRESHOLD;

  int unsigned zero_tally [fbd_pkg::NUM_BLOCK_COLS];
  int unsigned at_col      = 0;
  int unsigned at_row      = 0;
  int unsigned band_base   = 0;
  int unsigned flat_so_far = 0;

  fbd_pkg::res_t awaited_results [$];

  idle_mode_t in_mode  = IDLE_ANY;
  idle_mode_t out_mode = IDLE_ANY;

  int unsigned pixels_sent       = 0;
  int unsigned predicted_results = 0;
  int unsigned flat_predicted    = 0;
  int unsigned frames_predicted  = 0;
  int unsigned results_seen      = 0;
  int unsigned reg_writes        = 0;
  int unsigned error_count       = 0;
  int unsigned stalled_cycles    = 0;

  initial begin
    foreach (zero_tally[i]) zero_tally[i] = 0;
  end

  // Zero or oversized geometry behaves as 1 or as the maximum.
  function automatic int unsigned fit_dim(input logic [fbd_pkg::CFG_W-1:0] v,
                                          input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic int draw_wait(input idle_mode_t m);
    case (m)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 11) : 0;
      default:     return $urandom_range(0, 11);
    endcase
  endfunction

  function automatic logic [fbd_pkg::PIX_W-1:0] pick_edge(input int unsigned zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    return fbd_pkg::PIX_W'($urandom_range(1, 255));
  endfunction

  // Advance the detector state by one pixel and queue the result it causes, if any.
  function automatic void classify_pixel(input logic [fbd_pkg::PIX_W-1:0] px);
    int unsigned   w, h, bc, nbc;
    bit            row_done, last_px, band_done, blk_done, is_flat;
    fbd_pkg::res_t r;
    w         = fit_dim(reg_width, fbd_pkg::MAX_WIDTH);
    h         = fit_dim(reg_height, fbd_pkg::MAX_HEIGHT);
    bc        = at_col / fbd_pkg::BLOCK_SIZE;
    nbc       = (w + fbd_pkg::BLOCK_SIZE - 1) / fbd_pkg::BLOCK_SIZE;
    row_done  = (at_col + 1 >= w);
    last_px   = row_done && (at_row + 1 >= h);
    band_done = ((at_row % fbd_pkg::BLOCK_SIZE) == fbd_pkg::BLOCK_SIZE - 1) ||
                (at_row + 1 >= h);
    blk_done  = ((at_col % fbd_pkg::BLOCK_SIZE) == fbd_pkg::BLOCK_SIZE - 1) || row_done;
    is_flat   = 1'b0;
    r         = '0;
    if (bc >= fbd_pkg::NUM_BLOCK_COLS) bc = fbd_pkg::NUM_BLOCK_COLS - 1;

    if (px == 0 && zero_tally[bc] < fbd_pkg::CNT_MAX) zero_tally[bc]++;

    // A block closes on its last column in the band's last row.
    if (band_done && blk_done) begin
      if (zero_tally[bc] >= reg_threshold) begin
        is_flat       = 1'b1;
        r.block_valid = 1'b1;
        r.block_index = fbd_pkg::POS_W'(band_base + bc);
        if (flat_so_far < fbd_pkg::CNT_MAX) flat_so_far++;
      end
      zero_tally[bc] = 0;
    end

    if (is_flat || last_px) begin
      r.frame_end  = last_px;
      r.flat_total = fbd_pkg::CNT_W'(flat_so_far);
      awaited_results.push_back(r);
      predicted_results++;
      if (is_flat) flat_predicted++;
      if (last_px) frames_predicted++;
    end

    if (last_px) begin
      foreach (zero_tally[i]) zero_tally[i] = 0;
      at_col      = 0;
      at_row      = 0;
      band_base   = 0;
      flat_so_far = 0;
    end else if (row_done) begin
      at_col = 0;
      if (band_done) begin
        foreach (zero_tally[i]) zero_tally[i] = 0;
        band_base = (band_base + nbc) & 12'hFFF;
      end
      at_row = (at_row + 1) & 12'hFFF;
    end else begin
      at_col = (at_col + 1) & 12'hFFF;
    end
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side: one request per call, accepted when push is high and full low.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [fbd_pkg::PIX_W-1:0] px);
    int gap;
    gap = draw_wait(in_mode);
    // Drop push only when a gap follows, so back-to-back requests keep it high.
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    edge_value <= px;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    classify_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned count, input int unsigned zero_pct);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_edge(zero_pct));
  endtask

  // Hold the pixel side until every expected result is back, then let the
  // pipeline drain pixels that cause no result.
  task automatic settle_block();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_register(input logic [fbd_pkg::IDX_W-1:0] idx,
                                input logic [fbd_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_geometry(input logic [fbd_pkg::CFG_W-1:0] w, h, thr);
    settle_block();
    write_register(fbd_pkg::REG_IMAGE_WIDTH, w);
    write_register(fbd_pkg::REG_IMAGE_HEIGHT, h);
    write_register(fbd_pkg::REG_FLAT_THRESHOLD, thr);
    cfg_write     <= 1'b0;
    reg_width     = w;
    reg_height    = h;
    reg_threshold = thr;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls and compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin : result_check
    fbd_pkg::res_t want;
    int            stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(out_mode);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result valid=%0b index=%0d end=%0b total=%0d",
                             block_valid, block_index, frame_end, flat_total));
      end else begin
        want = awaited_results.pop_front();
        if (block_valid !== want.block_valid || block_index !== want.block_index ||
            frame_end !== want.frame_end || flat_total !== want.flat_total) begin
          flag_error($sformatf({"result %0d: want valid=%0b index=%0d end=%0b total=%0d,",
                                " got valid=%0b index=%0d end=%0b total=%0d"},
                               results_seen, want.block_valid, want.block_index,
                               want.frame_end, want.flat_total, block_valid,
                               block_index, frame_end, flat_total));
        end
      end
    end
  end

  // Abandon the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run one all-zero row at the reset width of 64, then cut the frame to two rows
  // and set the threshold to 127: the second row has one edge pixel, so the
  // single block closes flat exactly at the threshold on the frame's last pixel.
  task automatic test_reset_defaults();
    int unsigned hole;
    in_mode  = IDLE_SPARSE;
    out_mode = IDLE_ANY;
    send_frame(64, 100);
    set_geometry(fbd_pkg::RST_IMAGE_WIDTH, 13'd2, 13'd127);
    hole = $urandom_range(0, 63);
    for (int unsigned i = 0; i < 64; i++) send_pixel((i == hole) ? pick_edge(0) : 8'h00);
  endtask

  // One-, two- and six-pixel frames: flat on the last pixel, threshold zero, zero geometry.
  task automatic test_tiny_frames();
    in_mode  = IDLE_ANY;
    out_mode = IDLE_ANY;
    set_geometry(13'd1, 13'd1, 13'd1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'h80);
    set_geometry(13'd0, 13'd0, 13'd0);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h00);
    set_geometry(13'd2, 13'd1, 13'd2);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h07);
    set_geometry(13'd3, 13'd2, 13'd5);
    for (int i = 0; i < 6; i++) send_pixel((i == 4) ? 8'hFE : 8'h00);
  endtask

  // Threshold equal to the block area, one short of it, and above any block.
  task automatic test_threshold_limits();
    int unsigned hole;
    in_mode  = IDLE_SPARSE;
    out_mode = IDLE_SPARSE;
    set_geometry(13'd4, 13'd4, 13'd16);
    send_frame(16, 100);
    hole = $urandom_range(0, 15);
    for (int unsigned i = 0; i < 16; i++) send_pixel((i == hole) ? pick_edge(0) : 8'h00);
    set_geometry(13'd4, 13'd4, 13'd8191);
    send_frame(16, 100);
  endtask

  // Oversized width and zero height with threshold zero: the first 130 pixels of
  // the single row close two flat blocks; shrinking the width to 130 then ends
  // the row and the frame on the next pixel, closing a third block.
  task automatic test_wide_row();
    in_mode  = IDLE_SPARSE;
    out_mode = IDLE_NONE;
    set_geometry(13'd8191, 13'd0, 13'd0);
    send_frame(130, 50);
    set_geometry(13'd130, 13'd0, 13'd0);
    send_frame(1, 50);
  endtask

  // Shrink height and width below the current position mid-frame: the next
  // pixel must end the row and the frame.
  task automatic test_midframe_resize();
    in_mode  = IDLE_ANY;
    out_mode = IDLE_ANY;
    set_geometry(13'd1, 13'd8191, 13'd32);
    send_frame(70, 70);
    set_geometry(13'd1, 13'd40, 13'd32);
    send_frame(1, 70);
    set_geometry(13'd100, 13'd1, 13'd5);
    send_frame(50, 60);
    set_geometry(13'd20, 13'd1, 13'd5);
    send_frame(1, 60);
  endtask

  // Random small frames: tiny blocks, short wide strips crossing block columns,
  // narrow tall strips crossing bands, and now and then a frame cut short.
  task automatic test_random_frames();
    int unsigned first_px, first_res, w, h, area, count;
    first_px  = pixels_sent;
    first_res = predicted_results;
    while (pixels_sent - first_px < RANDOM_ITEMS ||
           predicted_results - first_res < RANDOM_RESULTS) begin
      case ($urandom_range(0, 4))
        3: begin
          w = $urandom_range(60, 100);
          h = $urandom_range(1, 2);
        end
        4: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(60, 100);
        end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 12);
        end
      endcase
      area     = ((w < fbd_pkg::BLOCK_SIZE) ? w : fbd_pkg::BLOCK_SIZE) *
                 ((h < fbd_pkg::BLOCK_SIZE) ? h : fbd_pkg::BLOCK_SIZE);
      in_mode  = idle_mode_t'($urandom_range(0, 2));
      out_mode = idle_mode_t'($urandom_range(0, 2));
      set_geometry(fbd_pkg::CFG_W'(w), fbd_pkg::CFG_W'(h),
                   fbd_pkg::CFG_W'($urandom_range(0, area + 1)));
      count = w * h;
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
      case ($urandom_range(0, 2))
        0:       send_frame(count, 60);
        1:       send_frame(count, 90);
        default: send_frame(count, 100);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_tiny_frames();
    test_threshold_limits();
    test_wide_row();
    test_midframe_resize();
    test_random_frames();

    // Drain: every expectation back, then a few quiet cycles to catch extras.
    settle_block();

    $display({"Sent %0d pixels over %0d register writes;",
              " checked %0d results (%0d flat, %0d frame ends)."},
             pixels_sent, reg_writes, results_seen, flat_predicted, frames_predicted);
    $display({"Geometry from 1x1 to clamped zero and oversized sizes, mid-frame resizes,",
              " thresholds 0 to 8191; %0d errors."},
             error_count);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
